>>> hw/rtl/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Types and constants for the signed binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned NumDigits = 19;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned CharW     = 6;
  localparam int unsigned PosW      = 5;
  localparam int unsigned DigIdxW   = $clog2(NumDigits);
  localparam int unsigned BitCntW   = $clog2(ValueW);

  localparam logic [CharW-1:0] CharMinus = 6'd45;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [NumDigits-1:0] bcd_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StEmit = 3'b100
  } state_e;

endpackage

>>> hw/rtl/signed_binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_unit
// Converts a signed 64-bit value to its decimal ASCII text, one character
// per output item, most significant first, using bit-serial double dabble.
// ----------------------------------------------------------------------------
// Flow: an accepted item is converted by the bit-serial BCD shift in StConv,
//   then StEmit registers one character per cycle while the output is not
//   stalled; no new item is accepted until its last character is issued.
// Reset: control state (FSM, counters, output valid) clears asynchronously.
module signed_binary_to_decimal_ascii_unit
  import sbda_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CharW-1:0]         char_code_o,
  output logic [PosW-1:0]          position_o,
  output logic                     last_o
);

  state_e               state_q, state_d;
  logic [ValueW-1:0]    mag_q, mag_d;
  bcd_t                 bcd_q, bcd_d;
  bcd_t                 corr;
  logic [BcdW-1:0]      corr_flat;
  logic [BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [PosW-1:0]      nd_q, nd_d;
  logic [PosW-1:0]      nd_conv;
  logic [DigIdxW-1:0]   top_idx;
  logic [DigIdxW-1:0]   dig_idx_q, dig_idx_d;
  logic                 sign_q, sign_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic                 out_valid_q, out_valid_d;
  logic [CharW-1:0]     char_q, char_d;
  logic [PosW-1:0]      opos_q, opos_d;
  logic                 last_q, last_d;
  logic [ValueW-1:0]    raw;
  logic                 out_free;

  assign raw       = value_i;
  assign out_free  = !out_valid_q || out_ready_i;
  assign top_idx   = DigIdxW'(nd_q - PosW'(1));

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      corr[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
    corr_flat = corr;
  end

  // significant digit count starts at one with the first set bit and grows when the top digit carries into the next
  always_comb begin
    if (nd_q == '0) begin
      nd_conv = mag_q[ValueW-1] ? PosW'(1) : '0;
    end else if (corr[top_idx][3]) begin
      nd_conv = nd_q + PosW'(1);
    end else begin
      nd_conv = nd_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    nd_d        = nd_q;
    dig_idx_d   = dig_idx_q;
    sign_d      = sign_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    opos_d      = opos_q;
    last_d      = last_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mag_d     = raw[ValueW-1] ? (~raw + ValueW'(1)) : raw;
          sign_d    = raw[ValueW-1];
          bcd_d     = '0;
          bit_cnt_d = '0;
          nd_d      = '0;
          state_d   = StConv;
        end
      end
      StConv: begin
        bcd_d     = bcd_t'({corr_flat[BcdW-2:0], mag_q[ValueW-1]});
        mag_d     = {mag_q[ValueW-2:0], 1'b0};
        nd_d      = nd_conv;
        bit_cnt_d = bit_cnt_q + BitCntW'(1);
        if (bit_cnt_q == BitCntW'(ValueW - 1)) begin
          if (nd_conv == '0) begin
            dig_idx_d = '0;
          end else begin
            dig_idx_d = DigIdxW'(nd_conv - PosW'(1));
          end
          pos_d   = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          opos_d      = pos_q;
          pos_d       = pos_q + PosW'(1);
          if (sign_q) begin
            char_d = CharMinus;
            last_d = 1'b0;
            sign_d = 1'b0;
          end else begin
            char_d    = CharZero + {2'b00, bcd_q[dig_idx_q]};
            last_d    = (dig_idx_q == '0);
            dig_idx_d = dig_idx_q - DigIdxW'(1);
            if (dig_idx_q == '0) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      nd_q        <= '0;
      dig_idx_q   <= '0;
      sign_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      nd_q        <= nd_d;
      dig_idx_q   <= dig_idx_d;
      sign_q      <= sign_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    opos_q <= opos_d;
    last_q <= last_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign position_o  = opos_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == StConv)
    else $error("accepted item did not start conversion");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> position_o <= PosW'(NumDigits))
    else $error("character position out of range");

  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_code_o == CharMinus |-> position_o == '0 && !last_o)
    else $error("sign character misplaced");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StConv |-> nd_q <= PosW'(NumDigits))
    else $error("digit count overflow");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_binary_to_decimal_ascii_unit. Signed 64-bit
// values go in over a valid/ready channel. A scoreboard spells each accepted
// value as decimal text and compares every character, its position and the
// last flag against the output stream. Directed edge values come first, then
// random values with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench
  import sbda_pkg::*;
();

  localparam int CycleLimit = 400000;
  localparam int NumRandom  = 360;
  localparam int HoldOff    = 600;
  localparam int DrainWait  = 100;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic [PosW-1:0]  pos;
    logic             last;
  } ascii_char_t;

  typedef enum int {RxOpen, RxCoin, RxEvery, RxMostly} rx_mode_e;

  class decimal_text_sb;
    ascii_char_t text_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // Expected text for one accepted value, most significant character first.
    function void spell_value(logic [ValueW-1:0] value);
      logic [ValueW-1:0] mag;
      logic              neg;
      logic [3:0]        digs [0:NumDigits-1];
      int                nd;
      int                total;
      int                pos;
      ascii_char_t       ch;
      neg = value[ValueW-1];
      mag = neg ? (~value + 64'd1) : value;
      nd  = 0;
      do begin
        digs[nd] = 4'(mag % 64'd10);
        mag      = mag / 64'd10;
        nd++;
      end while (mag != 0 && nd < NumDigits);
      total = nd + (neg ? 1 : 0);
      pos   = 0;
      if (neg) begin
        ch.code = CharMinus;
        ch.pos  = pos[PosW-1:0];
        ch.last = (pos == total - 1);
        text_q.push_back(ch);
        pos++;
      end
      for (int k = nd - 1; k >= 0; k--) begin
        ch.code = CharZero + digs[k];
        ch.pos  = pos[PosW-1:0];
        ch.last = (pos == total - 1);
        text_q.push_back(ch);
        pos++;
      end
    endfunction

    function void match_char(logic [CharW-1:0] code, logic [PosW-1:0] pos, logic last);
      ascii_char_t want;
      if (text_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected char: expected none, actual code %0d pos %0d last %0b",
                 $time, code, pos, last);
        return;
      end
      want = text_q.pop_front();
      if (want.code !== code) begin
        errors++;
        $display("%0t: char_code mismatch: expected %0d, actual %0d", $time, want.code, code);
      end
      if (want.pos !== pos) begin
        errors++;
        $display("%0t: position mismatch: expected %0d, actual %0d", $time, want.pos, pos);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
      end
    endfunction

    function int pending();
      return text_q.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [ValueW-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [CharW-1:0]         char_code_o;
  logic [PosW-1:0]          position_o;
  logic                     last_o;

  decimal_text_sb board;
  int             cycles = 0;

  signed_binary_to_decimal_ascii_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .char_code_o,
    .position_o,
    .last_o
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.spell_value(value_i);
      if (out_valid_o && out_ready_i) board.match_char(char_code_o, position_o, last_o);
    end
  end

  task automatic send_value(input logic [ValueW-1:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] v;
    logic [ValueW-1:0] p;
    int                w;
    int                k;
    case ($urandom_range(0, 5))
      0, 1: v = {$urandom, $urandom};
      2: begin
        w = $urandom_range(1, 63);
        v = {$urandom, $urandom} >> (ValueW - w);
      end
      3: v = 64'($urandom_range(0, 1000));
      4: begin
        p = 64'd1;
        k = $urandom_range(0, 18);
        repeat (k) p = p * 64'd10;
        v = p + $urandom_range(0, 4) - 64'd2;
      end
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          v = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
        end else begin
          v = 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
        end
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // receiver: random stall patterns, one long hold-off early on
  initial begin
    rx_mode_e mode;
    int       len;
    int       p;
    int       ph;
    out_ready_i = 1'b0;
    ph = 0;
    @(posedge rst_ni);
    forever begin
      if (ph == 3) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (HoldOff - 1) @(negedge clk_i);
      end else begin
        mode = rx_mode_e'($urandom_range(0, 3));
        len  = $urandom_range(20, 300);
        p    = $urandom_range(2, 4);
        for (int c = 0; c < len; c++) begin
          @(negedge clk_i);
          case (mode)
            RxOpen:  out_ready_i <= 1'b1;
            RxCoin:  out_ready_i <= ($urandom_range(0, 1) == 1);
            RxEvery: out_ready_i <= (c % p == 0);
            default: out_ready_i <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
      ph++;
    end
  end

  initial begin
    logic [ValueW-1:0] directed [$];
    int                burst;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    value_i    = '0;
    board      = new();
    directed = '{
      64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
      64'd12345, -64'd12345, 64'd999999999, 64'd1000000000,
      64'd4294967295, 64'd4294967296,
      64'd999999999999999999, 64'd1000000000000000000, -64'd1000000000000000000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE,
      64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'hAAAA_5555_AAAA_5555
    };
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    foreach (directed[i]) begin
      send_value(directed[i]);
      pause_sender($urandom_range(0, 3));
    end
    burst = 0;
    for (int i = 0; i < NumRandom; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                 : $urandom_range(0, 8));
      end
      send_value(random_value());
      burst--;
    end
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
